// ===== hw/rtl/zohr_pkg.sv =====
`default_nettype none

package zohr_pkg;

    // sample and rate widths
    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 18;
    localparam int ACC_W    = RATE_W + 1;
    localparam int CFG_W    = RATE_W;

    // converter defaults
    localparam int OUTPUT_RATE_DEF = 44100;
    localparam int MAX_PAIRS       = 6;
    localparam int CNT_W           = $clog2(MAX_PAIRS + 1);
    localparam int QUEUE_DEPTH     = 2;

    // register indexes
    localparam logic [1:0] REG_NATIVE_RATE = 2'd0;
    localparam logic [1:0] REG_STEREO      = 2'd1;
    localparam logic [1:0] REG_EIGHT_BIT   = 2'd2;

    localparam logic [RATE_W-1:0] NATIVE_RATE_RST = RATE_W'(44100);

    typedef struct packed {
        logic [RATE_W-1:0] native_rate;
        logic              stereo_input;
        logic              eight_bit_input;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } pair_t;

    typedef struct packed {
        logic             run;
        logic [CNT_W-1:0] count;
    } back_status_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zohr_front.sv =====
`default_nettype none

module zohr_front (
    input  wire  zohr_pkg::cfg_t                  cfg,
    input  wire  logic                            in_valid,
    output logic                                  in_stall,
    input  wire  logic [zohr_pkg::SAMPLE_W-1:0]   first_sample,
    input  wire  logic [zohr_pkg::SAMPLE_W-1:0]   second_sample,
    input  wire  logic                            q_full,
    output logic                                  q_push,
    output zohr_pkg::pair_t                       q_data
);

    logic [zohr_pkg::SAMPLE_W-1:0] left_wide;
    logic [zohr_pkg::SAMPLE_W-1:0] right_wide;

    // unsigned 8-bit becomes (u - 128) << 8, 16-bit passes as is
    always_comb
    begin
        if (cfg.eight_bit_input)
        begin
            left_wide  = {~first_sample[7], first_sample[6:0], 8'h00};
            right_wide = {~second_sample[7], second_sample[6:0], 8'h00};
        end
        else
        begin
            left_wide  = first_sample;
            right_wide = second_sample;
        end
    end

    // mono copies the first channel to both sides
    always_comb
    begin
        q_data.left  = $signed(left_wide);
        q_data.right = cfg.stereo_input ? $signed(right_wide) : $signed(left_wide);
    end

    // request goes into the queue whenever there is room
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

// ===== hw/rtl/zohr_queue.sv =====
`default_nettype none

module zohr_queue #(
    parameter int DEPTH = zohr_pkg::QUEUE_DEPTH
) (
    input  wire  logic             clk,
    input  wire  logic             rst_n,
    input  wire  logic             push,
    input  wire  zohr_pkg::pair_t  push_data,
    input  wire  logic             pop,
    output zohr_pkg::pair_t        pop_data,
    output logic                   full,
    output logic                   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    zohr_pkg::pair_t    mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/zohr_back.sv =====
`default_nettype none

module zohr_back #(
    parameter int OUTPUT_RATE = zohr_pkg::OUTPUT_RATE_DEF
) (
    input  wire  logic                                  clk,
    input  wire  logic                                  rst_n,
    input  wire  logic [zohr_pkg::RATE_W-1:0]           native_rate,
    input  wire  logic                                  q_empty,
    input  wire  zohr_pkg::pair_t                       q_data,
    output logic                                        q_pop,
    output logic                                        out_valid,
    input  wire  logic                                  out_stall,
    output logic signed [zohr_pkg::SAMPLE_W-1:0]        left_out,
    output logic signed [zohr_pkg::SAMPLE_W-1:0]        right_out,
    output logic                                        last_of_run,
    output zohr_pkg::back_status_t                      status
);

    localparam logic [zohr_pkg::ACC_W-1:0] STEP = zohr_pkg::ACC_W'(OUTPUT_RATE);

    zohr_pkg::back_state_t              state_reg, state_next;
    logic [zohr_pkg::ACC_W-1:0]         acc_reg, acc_next;
    logic [zohr_pkg::RATE_W-1:0]        phase_reg, phase_next;
    logic [zohr_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    zohr_pkg::pair_t                    pair_reg, pair_next;
    logic                               out_valid_reg, out_valid_next;
    zohr_pkg::pair_t                    out_pair_reg, out_pair_next;
    logic                               out_last_reg, out_last_next;

    logic [zohr_pkg::ACC_W-1:0]         rate_wide;
    logic [zohr_pkg::ACC_W-1:0]         diff;
    logic                               emit_ok;
    logic                               is_last;
    logic                               out_free;

    assign rate_wide = {1'b0, native_rate};
    assign diff      = acc_reg - rate_wide;
    assign emit_ok   = acc_reg > rate_wide;
    assign is_last   = (diff <= rate_wide) ||
                       (cnt_reg == zohr_pkg::CNT_W'(zohr_pkg::MAX_PAIRS - 1));
    assign out_free  = !out_valid_reg || !out_stall;

    function automatic logic [zohr_pkg::RATE_W-1:0] saturate(
        input logic [zohr_pkg::ACC_W-1:0] v
    );
        saturate = v[zohr_pkg::ACC_W-1] ? '1 : v[zohr_pkg::RATE_W-1:0];
    endfunction

    // sequencer: one pair per cycle while the accumulator exceeds the native rate and the output is not stalled
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        pair_next      = pair_reg;
        out_pair_next  = out_pair_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        case (state_reg)
            zohr_pkg::BACK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    pair_next  = q_data;
                    acc_next   = {1'b0, phase_reg} + STEP;
                    cnt_next   = '0;
                    state_next = zohr_pkg::BACK_RUN;
                end
            end
            zohr_pkg::BACK_RUN:
            begin
                if (!emit_ok)
                begin
                    phase_next = saturate(acc_reg);
                    state_next = zohr_pkg::BACK_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pair_next  = pair_reg;
                    out_last_next  = is_last;
                    acc_next       = diff;
                    cnt_next       = cnt_reg + 1'b1;
                    if (is_last)
                    begin
                        phase_next = saturate(diff);
                        state_next = zohr_pkg::BACK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = zohr_pkg::BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= zohr_pkg::BACK_IDLE;
            phase_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        pair_reg     <= pair_next;
        out_pair_reg <= out_pair_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign left_out     = out_pair_reg.left;
    assign right_out    = out_pair_reg.right;
    assign last_of_run  = out_last_reg;
    assign status.run   = (state_reg == zohr_pkg::BACK_RUN);
    assign status.count = cnt_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/zero_order_hold_resampler.sv =====
// Zero-order-hold resampler: native audio frames in, signed 16-bit stereo pairs out.
// Input channel: in_valid / in_stall with first_sample and second_sample; one request
// is one native frame (mono or stereo, unsigned 8-bit or signed 16-bit, per the
// configuration registers). Output channel: out_valid / out_stall with left_out,
// right_out and last_of_run; a frame yields zero to six pairs, the last one marked.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 native rate,
// 1 stereo input, 2 eight-bit input); write only while the block is idle.
// An accepted frame is written into the queue, popped into the back-end pair
// register while the sequencer is idle, and copied into the output register with
// each pair emitted. The back-end sequencer takes one frame at a time and emits
// one pair per cycle while the output is not stalled. A two-entry queue lets
// the front accept frames while the back-end is still emitting.
// Reset clears the phase register, the queue and the output valid flag and loads
// the default configuration (44100 Hz, stereo, 16-bit).
// When the receiver stalls, the output pair holds, the back-end waits, the queue
// fills and in_stall rises; nothing is dropped.
`default_nettype none

module zero_order_hold_resampler #(
    parameter int OUTPUT_RATE = zohr_pkg::OUTPUT_RATE_DEF
) (
    input  wire  logic                                  clk,
    input  wire  logic                                  rst_n,
    input  wire  logic                                  cfg_we,
    input  wire  logic [1:0]                            cfg_index,
    input  wire  logic [zohr_pkg::CFG_W-1:0]            cfg_data,
    input  wire  logic                                  in_valid,
    output logic                                        in_stall,
    input  wire  logic [zohr_pkg::SAMPLE_W-1:0]         first_sample,
    input  wire  logic [zohr_pkg::SAMPLE_W-1:0]         second_sample,
    output logic                                        out_valid,
    input  wire  logic                                  out_stall,
    output logic signed [zohr_pkg::SAMPLE_W-1:0]        left_out,
    output logic signed [zohr_pkg::SAMPLE_W-1:0]        right_out,
    output logic                                        last_of_run
);

    zohr_pkg::cfg_t          cfg_reg, cfg_next;
    zohr_pkg::pair_t         push_data;
    zohr_pkg::pair_t         pop_data;
    zohr_pkg::back_status_t  back_status;
    logic                    q_full;
    logic                    q_empty;
    logic                    q_push;
    logic                    q_pop;

    // configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                zohr_pkg::REG_NATIVE_RATE: cfg_next.native_rate     = cfg_data;
                zohr_pkg::REG_STEREO:      cfg_next.stereo_input    = cfg_data[0];
                zohr_pkg::REG_EIGHT_BIT:   cfg_next.eight_bit_input = cfg_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.native_rate     <= zohr_pkg::NATIVE_RATE_RST;
            cfg_reg.stereo_input    <= 1'b1;
            cfg_reg.eight_bit_input <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and widen frames
    zohr_front u_front (
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_sample  (first_sample),
        .second_sample (second_sample),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (push_data)
    );

    // queue between front and back
    zohr_queue #(
        .DEPTH (zohr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: phase accumulator and pair emission
    zohr_back #(
        .OUTPUT_RATE (OUTPUT_RATE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .native_rate (cfg_reg.native_rate),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_out    (left_out),
        .right_out   (right_out),
        .last_of_run (last_of_run),
        .status      (back_status)
    );

    // emission count never passes the per-frame cap
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.run |-> (back_status.count < zohr_pkg::CNT_W'(zohr_pkg::MAX_PAIRS)))
        else $error("pair count beyond cap");

    // an accepted frame is in the queue on the next cycle
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !q_empty)
        else $error("accepted frame missing from queue");

    // a pair that is not the last of its run means the back-end is still on that frame
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> back_status.run)
        else $error("run closed without a last pair");

endmodule

`default_nettype wire
